// ===== sv/trsd_pkg.sv =====
// package: shared types, constants and color expansion for the rle sprite decoder
`default_nettype none

package trsd_pkg;

    // geometry limits
    localparam int unsigned MAX_DIM = 1023;
    localparam int unsigned DIM_W   = 10;
    localparam int unsigned COL_W   = 11;
    localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

    // stream codes
    localparam logic [7:0]  CTRL_SKIP = 8'hFF;
    localparam logic [7:0]  CTRL_NONE = 8'h00;
    localparam logic [15:0] KEY_COLOR = 16'hF81F;
    localparam logic [7:0]  ALPHA     = 8'hFF;

    // register map
    localparam int unsigned ADDR_W  = 3;
    localparam logic        REG_WIDTH  = 1'b0;
    localparam logic        REG_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(58);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(30);

    typedef enum logic [1:0] {
        MODE_CTRL = 2'd0,
        MODE_SKIP = 2'd1,
        MODE_LOW  = 2'd2,
        MODE_HIGH = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [DIM_W-1:0] pixel_x;
        logic [DIM_W-1:0] pixel_y;
        logic [31:0]      pixel_argb;
    } t_out_item;

    // rgb555 to argb8888, bit 15 ignored: red and blue by bit replication, green as g5, a zero bit, g5[4:3]
    function automatic logic [31:0] expand555(input logic [15:0] c);
        logic [4:0] r5;
        logic [4:0] g5;
        logic [4:0] b5;
        r5 = c[14:10];
        g5 = c[9:5];
        b5 = c[4:0];
        return {ALPHA, r5, r5[4:2], g5, 1'b0, g5[4:3], b5, b5[4:2]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/transparent_rle_sprite_decoder.sv =====
// top level: byte-serial transparent rle sprite decoder with apb configuration
//
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-------------------------
// in        | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
// out       | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
// config    | input     | psel penable pwrite pready | paddr pwdata prdata
//
// one byte per cycle while o_in_ready is high: each accepted byte updates the
// parser state, and a completed pixel enters the output register at that edge.
// the input is ready whenever the output register is empty or being taken, so
// a stalled output holds back only the input, one transaction deep.
// synchronous active-low reset clears parser, position and output valid and
// loads the default width and height.
`default_nettype none

module transparent_rle_sprite_decoder (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // byte stream
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  trsd_pkg::t_in_item           i_in_data,
    // pixel stream
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output trsd_pkg::t_out_item                o_out_data,
    // configuration
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [trsd_pkg::ADDR_W-1:0]        paddr,
    input  wire  [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // configuration registers
    logic [trsd_pkg::DIM_W-1:0] r_width;
    logic [trsd_pkg::DIM_W-1:0] r_height;

    // parser state
    trsd_pkg::t_mode            r_mode,      n_mode;
    logic [7:0]                 r_run_left,  n_run_left;
    logic [7:0]                 r_low_hold,  n_low_hold;
    logic [trsd_pkg::COL_W-1:0] r_column,    n_column;
    logic [trsd_pkg::DIM_W-1:0] r_row,       n_row;

    // output register
    logic                       r_out_valid;
    trsd_pkg::t_out_item        r_out_data;
    logic                       n_emit;
    trsd_pkg::t_out_item        n_out_data;

    logic                       in_fire;
    logic                       cfg_write;

    // helpers for the combinational step
    logic [trsd_pkg::COL_W:0]   skip_sum;
    logic [trsd_pkg::COL_W-1:0] skip_sat;
    logic [trsd_pkg::COL_W:0]   col_inc;
    logic [15:0]                color;
    logic [trsd_pkg::DIM_W-1:0] row_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // register read
    always_comb begin
        case (paddr[2])
            trsd_pkg::REG_WIDTH:  prdata = {{(32-trsd_pkg::DIM_W){1'b0}}, r_width};
            trsd_pkg::REG_HEIGHT: prdata = {{(32-trsd_pkg::DIM_W){1'b0}}, r_height};
            default:              prdata = '0;
        endcase
    end

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= trsd_pkg::WIDTH_RESET;
            r_height <= trsd_pkg::HEIGHT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == trsd_pkg::REG_WIDTH) begin
                r_width <= pwdata[trsd_pkg::DIM_W-1:0];
            end else begin
                r_height <= pwdata[trsd_pkg::DIM_W-1:0];
            end
        end
    end

    // saturating row advance
    always_comb begin
        if (r_row < trsd_pkg::DIM_W'(trsd_pkg::MAX_DIM)) begin
            row_next = r_row + trsd_pkg::DIM_W'(1);
        end else begin
            row_next = r_row;
        end
    end

    // per-byte parser step
    always_comb begin
        n_mode     = r_mode;
        n_run_left = r_run_left;
        n_low_hold = r_low_hold;
        n_column   = r_column;
        n_row      = r_row;
        n_emit     = 1'b0;

        skip_sum = {1'b0, r_column} + {{(trsd_pkg::COL_W+1-8){1'b0}}, i_in_data.byte_value};
        skip_sat = skip_sum[trsd_pkg::COL_W] ? trsd_pkg::COL_MAX
                                             : skip_sum[trsd_pkg::COL_W-1:0];
        col_inc  = {1'b0, r_column} + (trsd_pkg::COL_W+1)'(1);
        color    = {i_in_data.byte_value, r_low_hold};

        n_out_data.pixel_x    = r_column[trsd_pkg::DIM_W-1:0];
        n_out_data.pixel_y    = r_row;
        n_out_data.pixel_argb = trsd_pkg::expand555(color);

        case (r_mode)
            trsd_pkg::MODE_CTRL: begin
                if (i_in_data.byte_value == trsd_pkg::CTRL_SKIP) begin
                    n_mode = trsd_pkg::MODE_SKIP;
                end else if (i_in_data.byte_value != trsd_pkg::CTRL_NONE) begin
                    n_run_left = i_in_data.byte_value;
                    n_mode     = trsd_pkg::MODE_LOW;
                end
            end
            trsd_pkg::MODE_SKIP: begin
                if (skip_sat >= {1'b0, r_width}) begin
                    n_column = skip_sat - {1'b0, r_width};
                    n_row    = row_next;
                end else begin
                    n_column = skip_sat;
                end
                n_mode = trsd_pkg::MODE_CTRL;
            end
            trsd_pkg::MODE_LOW: begin
                n_low_hold = i_in_data.byte_value;
                n_mode     = trsd_pkg::MODE_HIGH;
            end
            trsd_pkg::MODE_HIGH: begin
                n_emit = (color != trsd_pkg::KEY_COLOR)
                      && (r_column < {1'b0, r_width})
                      && (r_row < r_height);
                if (col_inc >= {2'b00, r_width}) begin
                    n_column = '0;
                    n_row    = row_next;
                end else begin
                    n_column = col_inc[trsd_pkg::COL_W-1:0];
                end
                n_run_left = r_run_left - 8'd1;
                n_mode     = (n_run_left == 8'd0) ? trsd_pkg::MODE_CTRL
                                                  : trsd_pkg::MODE_LOW;
            end
            default: begin
                n_mode = trsd_pkg::MODE_CTRL;
            end
        endcase

        // end of sprite returns the parser to its start
        if (i_in_data.last_byte) begin
            n_mode     = trsd_pkg::MODE_CTRL;
            n_run_left = '0;
            n_low_hold = '0;
            n_column   = '0;
            n_row      = '0;
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= trsd_pkg::MODE_CTRL;
            r_run_left <= '0;
            r_low_hold <= '0;
            r_column   <= '0;
            r_row      <= '0;
        end else if (in_fire) begin
            r_mode     <= n_mode;
            r_run_left <= n_run_left;
            r_low_hold <= n_low_hold;
            r_column   <= n_column;
            r_row      <= n_row;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (in_fire && n_emit) begin
            r_out_data <= n_out_data;
        end
    end

    // no run is pending while waiting for a control or skip byte
    a_idle_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == trsd_pkg::MODE_CTRL || r_mode == trsd_pkg::MODE_SKIP)
            |-> (r_run_left == 8'd0))
        else $error("run count left over outside a pixel run");

    // inside a run at least one pixel remains
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == trsd_pkg::MODE_LOW || r_mode == trsd_pkg::MODE_HIGH)
            |-> (r_run_left != 8'd0))
        else $error("pixel run active with zero count");

    // row counter saturates
    a_row_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= trsd_pkg::DIM_W'(trsd_pkg::MAX_DIM))
        else $error("row counter beyond its limit");

    // last byte of a sprite clears the position
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.last_byte)
            |=> (r_mode == trsd_pkg::MODE_CTRL && r_column == '0 && r_row == '0))
        else $error("parser not cleared after last byte");

endmodule

`default_nettype wire
